// File: rtl/cylinder_radial_histogram_macros.svh
// Assertion macros for the cylinder radial histogram block.
// Included by rtl/cylinder_radial_histogram.sv; needs no other file.
`ifndef CYLINDER_RADIAL_HISTOGRAM_MACROS_SVH
`define CYLINDER_RADIAL_HISTOGRAM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHR_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("cylinder_radial_histogram: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("cylinder_radial_histogram: assertion failed");

`endif

// File: rtl/chr_pkg.sv
// Shared constants, codes and interface types of the cylinder radial histogram.
// No dependencies; used by chr_radial.sv and cylinder_radial_histogram.sv.
package chr_pkg;

  localparam int NBIN      = 128;
  localparam int BIN_W     = $clog2(NBIN);
  localparam int HIT_W     = 7;
  localparam int RBIN_W    = 7;
  localparam int CNT_W     = 32;
  localparam int POS_W     = 32;
  localparam int RAD_W     = 24;
  localparam int ROOT_W    = RAD_W + 1;
  localparam int R2_W      = 2 * ROOT_W;
  localparam int MUL_STEPS = RAD_W / 2;
  localparam int SQ_STEPS  = ROOT_W;
  localparam int Q_W       = $clog2(NBIN + 1);
  localparam int DIV_W     = RAD_W + Q_W;
  localparam int STEP_W    = $clog2(SQ_STEPS);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam logic [1:0] REQ_POS   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_FRAME = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_Z_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Z_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd4;

  localparam logic [POS_W-1:0] Z_LOW_RST    = 32'd508625;
  localparam logic [POS_W-1:0] Z_HIGH_RST   = 32'd802095;
  localparam logic [POS_W-1:0] CENTER_X_RST = 32'd185401;
  localparam logic [POS_W-1:0] CENTER_Y_RST = 32'd134742;
  localparam logic [RAD_W-1:0] RADIUS_RST   = 24'd60752;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic             go;
    logic [RAD_W-1:0] ax;
    logic [RAD_W-1:0] ay;
    logic [RAD_W-1:0] rad;
  } rad_req_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [BIN_W-1:0] bin;
  } rad_res_t;

endpackage

// File: rtl/cylinder_radial_histogram.sv
// Top level of the cylinder radial histogram: request control, bin store, frame counter.
// Depends on chr_pkg, chr_radial and cylinder_radial_histogram_macros.svh.
//
//   Channel   Handshake              Contents
//   request   start / busy           in_req_type, in_pos_x/y/z, in_read_bin,
//                                    in_clear_after_read
//   result    out_valid (strobe)     out_accepted, out_hit_bin, out_bin_count,
//                                    out_frames_seen
//   config    cfg_we                 cfg_index, cfg_data
//
// A request is taken when start is high and busy is low. A position inside the
// pore passes the offset, abs and box-check states, then the radial unit (operand
// load, radix-4 squaring, one root bit a cycle, rim check, one quotient bit a
// cycle), then the handoff and the read-modify-write of the bin store, and then
// strobes. A position outside the slab or the bounding box strobes after the box
// check, one outside the circle after the rim check, and one binned under a zero
// radius skips the division. A read strobes after the read and update states of
// the bin store; end-of-frame and unused requests strobe the cycle after they are
// taken and never raise busy. The next request may be taken in the strobe cycle.
// Reset clears the valid bit of every bin and the frame counter at once. Results
// cannot be stalled.
`include "cylinder_radial_histogram_macros.svh"

module cylinder_radial_histogram (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_req_type,
  input  logic signed [chr_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [chr_pkg::POS_W-1:0]    in_pos_y,
  input  logic signed [chr_pkg::POS_W-1:0]    in_pos_z,
  input  logic [chr_pkg::RBIN_W-1:0]          in_read_bin,
  input  logic                                in_clear_after_read,
  output logic                                out_valid,
  output logic                                out_accepted,
  output logic [chr_pkg::HIT_W-1:0]           out_hit_bin,
  output logic [chr_pkg::CNT_W-1:0]           out_bin_count,
  output logic [chr_pkg::CNT_W-1:0]           out_frames_seen,
  input  logic                                cfg_we,
  input  logic [chr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [chr_pkg::CFG_W-1:0]           cfg_data
);

  localparam int POS_W = chr_pkg::POS_W;
  localparam int RAD_W = chr_pkg::RAD_W;
  localparam int CNT_W = chr_pkg::CNT_W;
  localparam int BIN_W = chr_pkg::BIN_W;
  localparam int HIT_W = chr_pkg::HIT_W;
  localparam int NBIN  = chr_pkg::NBIN;
  localparam int DW    = POS_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIFF = 3'd1;
  localparam logic [2:0] S_ABS  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_MRD  = 3'd5;
  localparam logic [2:0] S_MUPD = 3'd6;

  logic [2:0]              state_r, state_nxt;

  // Configuration registers.
  logic signed [POS_W-1:0] zl_r, zl_nxt, zh_r, zh_nxt, cx_r, cx_nxt, cy_r, cy_nxt;
  logic [RAD_W-1:0]        rad_r, rad_nxt;

  // Latched request.
  logic [1:0]              req_r, req_nxt;
  logic signed [POS_W-1:0] px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;
  logic                    clr_r, clr_nxt, rok_r, rok_nxt;

  // Geometry pipeline.
  logic signed [DW-1:0]    dx_r, dx_nxt, dy_r, dy_nxt;
  logic [DW-1:0]           ax_r, ax_nxt, ay_r, ay_nxt;
  logic                    zin_r, zin_nxt;

  // Bin store and frame counter.
  logic [CNT_W-1:0]        bin_mem [NBIN];
  logic [NBIN-1:0]         vld_r;
  logic [BIN_W-1:0]        mem_a_r, mem_a_nxt;
  logic [CNT_W-1:0]        mem_q_r, mem_wd, cur;
  logic                    vq_r, mem_we, vld_set, vld_clr;
  logic [CNT_W-1:0]        frm_r, frm_nxt;

  // Result registers.
  logic                    out_valid_r, out_valid_nxt, out_acc_r, out_acc_nxt;
  logic [HIT_W-1:0]        out_hit_r, out_hit_nxt;
  logic [CNT_W-1:0]        out_cnt_r, out_cnt_nxt;

  logic                    take, frm_bump;
  chr_pkg::rad_req_t       rad_req;
  chr_pkg::rad_res_t       rad_res;

  assign busy = (state_r != S_IDLE);
  assign take = start && !busy;

  // An end-of-frame request taken while the frame count is below saturation.
  assign frm_bump = take && (in_req_type == chr_pkg::REQ_FRAME) && (frm_r != chr_pkg::CNT_MAX);

  // A bin that has not been written since reset or since it was cleared reads as zero.
  assign cur = vq_r ? mem_q_r : '0;

  always_comb begin
    state_nxt     = state_r;
    zl_nxt        = zl_r;
    zh_nxt        = zh_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    rad_nxt       = rad_r;
    req_nxt       = req_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pz_nxt        = pz_r;
    clr_nxt       = clr_r;
    rok_nxt       = rok_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    zin_nxt       = zin_r;
    mem_a_nxt     = mem_a_r;
    mem_we        = 1'b0;
    mem_wd        = (cur == chr_pkg::CNT_MAX) ? cur : (cur + CNT_W'(1));
    vld_set       = 1'b0;
    vld_clr       = 1'b0;
    frm_nxt       = frm_r;
    out_valid_nxt = 1'b0;
    out_acc_nxt   = out_acc_r;
    out_hit_nxt   = out_hit_r;
    out_cnt_nxt   = out_cnt_r;
    rad_req.go    = 1'b0;
    rad_req.ax    = ax_r[RAD_W-1:0];
    rad_req.ay    = ay_r[RAD_W-1:0];
    rad_req.rad   = rad_r;

    if (cfg_we) begin
      unique case (cfg_index)
        chr_pkg::REG_Z_LOW:    zl_nxt  = cfg_data;
        chr_pkg::REG_Z_HIGH:   zh_nxt  = cfg_data;
        chr_pkg::REG_CENTER_X: cx_nxt  = cfg_data;
        chr_pkg::REG_CENTER_Y: cy_nxt  = cfg_data;
        chr_pkg::REG_RADIUS:   rad_nxt = cfg_data[RAD_W-1:0];
        default: begin
        end
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          req_nxt = in_req_type;
          px_nxt  = in_pos_x;
          py_nxt  = in_pos_y;
          pz_nxt  = in_pos_z;
          clr_nxt = in_clear_after_read;
          rok_nxt = (int'(in_read_bin) < NBIN);
          unique case (in_req_type)
            chr_pkg::REQ_POS: begin
              state_nxt = S_DIFF;
            end
            chr_pkg::REQ_READ: begin
              mem_a_nxt = BIN_W'(in_read_bin);
              state_nxt = S_MRD;
            end
            chr_pkg::REQ_FRAME: begin
              frm_nxt       = (frm_r == chr_pkg::CNT_MAX) ? frm_r : (frm_r + CNT_W'(1));
              out_valid_nxt = 1'b1;
              out_acc_nxt   = 1'b0;
              out_hit_nxt   = '0;
              out_cnt_nxt   = '0;
            end
            default: begin
              // Unused request code: empty result, no state change.
              out_valid_nxt = 1'b1;
              out_acc_nxt   = 1'b0;
              out_hit_nxt   = '0;
              out_cnt_nxt   = '0;
            end
          endcase
        end
      end
      S_DIFF: begin
        // Offsets from the pore axis are exact in 33 bits.
        dx_nxt    = {px_r[POS_W-1], px_r} - {cx_r[POS_W-1], cx_r};
        dy_nxt    = {py_r[POS_W-1], py_r} - {cy_r[POS_W-1], cy_r};
        zin_nxt   = (pz_r >= zl_r) && (pz_r < zh_r);
        state_nxt = S_ABS;
      end
      S_ABS: begin
        ax_nxt    = dx_r[DW-1] ? DW'(-dx_r) : DW'(dx_r);
        ay_nxt    = dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);
        state_nxt = S_CHK;
      end
      S_CHK: begin
        // The bounding square keeps both offsets inside the radius width,
        // so the radial unit only ever sees 24-bit magnitudes.
        if (zin_r && (ax_r <= DW'(rad_r)) && (ay_r <= DW'(rad_r))) begin
          rad_req.go = 1'b1;
          state_nxt  = S_WAIT;
        end else begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = 1'b0;
          out_hit_nxt   = '0;
          out_cnt_nxt   = '0;
          state_nxt     = S_IDLE;
        end
      end
      S_WAIT: begin
        if (rad_res.done) begin
          if (rad_res.hit) begin
            mem_a_nxt = rad_res.bin;
            state_nxt = S_MRD;
          end else begin
            out_valid_nxt = 1'b1;
            out_acc_nxt   = 1'b0;
            out_hit_nxt   = '0;
            out_cnt_nxt   = '0;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_MRD: begin
        // The registered read of the bin store lands at the end of this cycle.
        state_nxt = S_MUPD;
      end
      S_MUPD: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (req_r == chr_pkg::REQ_POS) begin
          // Saturating increment of the hit bin.
          mem_we      = 1'b1;
          vld_set     = 1'b1;
          out_acc_nxt = 1'b1;
          out_hit_nxt = HIT_W'(mem_a_r);
          out_cnt_nxt = '0;
        end else begin
          // Read request: report the count before any clear.
          vld_clr     = rok_r && clr_r;
          out_acc_nxt = 1'b0;
          out_hit_nxt = '0;
          out_cnt_nxt = rok_r ? cur : '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  chr_radial u_radial (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rad_req),
    .res   (rad_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      zl_r        <= chr_pkg::Z_LOW_RST;
      zh_r        <= chr_pkg::Z_HIGH_RST;
      cx_r        <= chr_pkg::CENTER_X_RST;
      cy_r        <= chr_pkg::CENTER_Y_RST;
      rad_r       <= chr_pkg::RADIUS_RST;
      frm_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      zl_r        <= zl_nxt;
      zh_r        <= zh_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      rad_r       <= rad_nxt;
      frm_r       <= frm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    pz_r      <= pz_nxt;
    clr_r     <= clr_nxt;
    rok_r     <= rok_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    ax_r      <= ax_nxt;
    ay_r      <= ay_nxt;
    zin_r     <= zin_nxt;
    mem_a_r   <= mem_a_nxt;
    out_acc_r <= out_acc_nxt;
    out_hit_r <= out_hit_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  // Bin store: one write port and one registered read port at the same address.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem[mem_a_r] <= mem_wd;
    end
    mem_q_r <= bin_mem[mem_a_r];
    vq_r    <= vld_r[mem_a_r];
  end

  // Per-bin valid bits stand in for clearing the store; a cleared bin just drops its bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (vld_set) begin
        vld_r[mem_a_r] <= 1'b1;
      end else if (vld_clr) begin
        vld_r[mem_a_r] <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_acc_r;
  assign out_hit_bin     = out_hit_r;
  assign out_bin_count   = out_cnt_r;
  assign out_frames_seen = frm_r;

  // The radial unit only finishes while the controller is waiting for it.
  `CHR_ASSERT_IMPL(a_done_in_wait, clk, rst_n, rad_res.done, state_r == S_WAIT)
  // Requests that raise busy strobe only after busy has dropped again.
  `CHR_ASSERT_IMPL(a_no_strobe_busy, clk, rst_n, busy, !out_valid)
  // An end-of-frame request below saturation advances the frame count by one.
  `CHR_ASSERT_NEXT(a_frame_incr, clk, rst_n, frm_bump, frm_r == $past(frm_r) + 32'd1)

endmodule

// File: rtl/chr_radial.sv
// Digit-serial radial unit: squares, integer square root and bin division.
// Depends on chr_pkg.
module chr_radial (
  input  logic              clk,
  input  logic              rst_n,
  input  chr_pkg::rad_req_t req,
  output chr_pkg::rad_res_t res
);

  localparam int RAD_W  = chr_pkg::RAD_W;
  localparam int ROOT_W = chr_pkg::ROOT_W;
  localparam int R2_W   = chr_pkg::R2_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int SH_W   = REM_W + 2;
  localparam int DIV_W  = chr_pkg::DIV_W;
  localparam int Q_W    = chr_pkg::Q_W;
  localparam int BIN_W  = chr_pkg::BIN_W;
  localparam int STEP_W = chr_pkg::STEP_W;

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_LOAD = 3'd1;
  localparam logic [2:0] U_MUL  = 3'd2;
  localparam logic [2:0] U_SQRT = 3'd3;
  localparam logic [2:0] U_CHK  = 3'd4;
  localparam logic [2:0] U_DIV  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [RAD_W-1:0]  ax_r, ax_nxt, ay_r, ay_nxt, rad_r, rad_nxt;
  logic [RAD_W+1:0]  ax3_r, ax3_nxt, ay3_r, ay3_nxt;
  logic [RAD_W-1:0]  mx_r, mx_nxt, my_r, my_nxt;
  logic [R2_W-1:0]   acc_r, acc_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  num_r, num_nxt, den_r, den_nxt;
  logic [Q_W-1:0]    quo_r, quo_nxt;
  logic              done_r, done_nxt, hit_r, hit_nxt;
  logic [BIN_W-1:0]  bin_r, bin_nxt;

  logic [SH_W-1:0]   sq_sh, sq_try, sq_dif;
  logic              sq_ge, dv_ge, in_pore;

  // One radix-4 digit of the multiplier selects 0, a, 2a or 3a.
  function automatic logic [RAD_W+1:0] pick(input logic [RAD_W-1:0] a,
                                            input logic [RAD_W+1:0] a3,
                                            input logic [1:0]       d);
    logic [RAD_W+1:0] p;
    unique case (d)
      2'd0:    p = '0;
      2'd1:    p = {2'b00, a};
      2'd2:    p = {1'b0, a, 1'b0};
      default: p = a3;
    endcase
    return p;
  endfunction

  always_comb begin
    sq_sh   = {rem_r, acc_r[R2_W-1 -: 2]};
    sq_try  = {2'b00, root_r, 2'b01};
    sq_ge   = (sq_sh >= sq_try);
    sq_dif  = sq_sh - sq_try;
    dv_ge   = (num_r >= den_r);
    in_pore = (root_r < ROOT_W'(rad_r)) ||
              ((root_r == ROOT_W'(rad_r)) && (rem_r == '0));

    state_nxt  = state_r;
    step_nxt   = step_r;
    ax_nxt     = ax_r;
    ay_nxt     = ay_r;
    rad_nxt    = rad_r;
    ax3_nxt    = ax3_r;
    ay3_nxt    = ay3_r;
    mx_nxt     = mx_r;
    my_nxt     = my_r;
    acc_nxt    = acc_r;
    root_nxt   = root_r;
    rem_nxt    = rem_r;
    num_nxt    = num_r;
    den_nxt    = den_r;
    quo_nxt    = quo_r;
    done_nxt   = 1'b0;
    hit_nxt    = hit_r;
    bin_nxt    = bin_r;

    unique case (state_r)
      U_IDLE: begin
        if (req.go) begin
          ax_nxt    = req.ax;
          ay_nxt    = req.ay;
          rad_nxt   = req.rad;
          mx_nxt    = req.ax;
          my_nxt    = req.ay;
          acc_nxt   = '0;
          state_nxt = U_LOAD;
        end
      end
      U_LOAD: begin
        ax3_nxt   = {2'b00, ax_r} + {1'b0, ax_r, 1'b0};
        ay3_nxt   = {2'b00, ay_r} + {1'b0, ay_r, 1'b0};
        step_nxt  = STEP_W'(chr_pkg::MUL_STEPS - 1);
        state_nxt = U_MUL;
      end
      U_MUL: begin
        // Both squares accumulate MSB first, two multiplier bits a cycle.
        acc_nxt = {acc_r[R2_W-3:0], 2'b00}
                + R2_W'(pick(ax_r, ax3_r, mx_r[RAD_W-1 -: 2]))
                + R2_W'(pick(ay_r, ay3_r, my_r[RAD_W-1 -: 2]));
        mx_nxt  = {mx_r[RAD_W-3:0], 2'b00};
        my_nxt  = {my_r[RAD_W-3:0], 2'b00};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          root_nxt  = '0;
          rem_nxt   = '0;
          step_nxt  = STEP_W'(chr_pkg::SQ_STEPS - 1);
          state_nxt = U_SQRT;
        end
      end
      U_SQRT: begin
        // Restoring square root: the sum of squares shifts out two bits a cycle.
        acc_nxt  = {acc_r[R2_W-3:0], 2'b00};
        rem_nxt  = sq_ge ? sq_dif[REM_W-1:0] : sq_sh[REM_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], sq_ge};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = U_CHK;
        end
      end
      U_CHK: begin
        if (!in_pore || (rad_r == '0)) begin
          done_nxt   = 1'b1;
          hit_nxt    = in_pore;
          bin_nxt    = '0;
          state_nxt  = U_IDLE;
        end else begin
          num_nxt   = DIV_W'(root_r[RAD_W-1:0]) * DIV_W'(chr_pkg::NBIN);
          den_nxt   = DIV_W'(rad_r) << (Q_W - 1);
          quo_nxt   = '0;
          step_nxt  = STEP_W'(Q_W - 1);
          state_nxt = U_DIV;
        end
      end
      U_DIV: begin
        num_nxt  = dv_ge ? (num_r - den_r) : num_r;
        den_nxt  = den_r >> 1;
        quo_nxt  = {quo_r[Q_W-2:0], dv_ge};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          // A point on the rim lands one past the last bin and is folded back.
          done_nxt   = 1'b1;
          hit_nxt    = 1'b1;
          bin_nxt    = (quo_nxt >= Q_W'(chr_pkg::NBIN)) ? BIN_W'(chr_pkg::NBIN - 1)
                                                        : quo_nxt[BIN_W-1:0];
          state_nxt  = U_IDLE;
        end
      end
      default: begin
        state_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    ax_r     <= ax_nxt;
    ay_r     <= ay_nxt;
    rad_r    <= rad_nxt;
    ax3_r    <= ax3_nxt;
    ay3_r    <= ay3_nxt;
    mx_r     <= mx_nxt;
    my_r     <= my_nxt;
    acc_r    <= acc_nxt;
    root_r   <= root_nxt;
    rem_r    <= rem_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    quo_r    <= quo_nxt;
    hit_r    <= hit_nxt;
    bin_r    <= bin_nxt;
  end

  assign res.done   = done_r;
  assign res.hit    = hit_r;
  assign res.bin    = bin_r;

endmodule
